>>> hdl/cpc_pkg.sv
// Shared types, constants and the arctangent table for the cartesian/polar converter.
`default_nettype none

package cpc_pkg;

    localparam int CPC_COORD_BITS      = 16;
    localparam int CPC_ROTATION_STAGES = 16;
    localparam int CPC_GUARD_BITS      = 16;
    localparam int CPC_ANGLE_BITS      = 32;
    // datapath width: coordinate, guard fraction, CORDIC growth and sign
    localparam int CPC_DATA_BITS       = CPC_COORD_BITS + CPC_GUARD_BITS + 3;

    // 1/K in Q0.32
    localparam logic [CPC_ANGLE_BITS-1:0] CPC_INV_GAIN     = 32'h9B74_EDA8;
    localparam logic [CPC_ANGLE_BITS-1:0] CPC_HALF_TURN    = 32'h8000_0000;
    localparam logic [CPC_ANGLE_BITS-1:0] CPC_QUARTER_TURN = 32'h4000_0000;

    typedef enum logic {
        CPC_TO_POLAR = 1'b0,
        CPC_TO_CART  = 1'b1
    } t_cpc_func;

    typedef struct packed {
        t_cpc_func                          func;
        logic signed [CPC_COORD_BITS-1:0]   in_x;
        logic signed [CPC_COORD_BITS-1:0]   in_y;
        logic        [CPC_COORD_BITS-1:0]   in_magnitude;
        logic signed [CPC_COORD_BITS-1:0]   in_angle;
    } t_cpc_in;

    typedef struct packed {
        logic        [CPC_COORD_BITS-1:0]   out_magnitude;
        logic signed [CPC_COORD_BITS-1:0]   out_angle;
        logic signed [CPC_COORD_BITS-1:0]   out_x;
        logic signed [CPC_COORD_BITS-1:0]   out_y;
    } t_cpc_out;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic      valid;
        t_cpc_func func;
        logic      origin;
    } t_cpc_ctl;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [CPC_ANGLE_BITS-1:0] cpc_atan(input logic [4:0] idx);
        logic [CPC_ANGLE_BITS-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cpc_pre.sv
// Input conditioning: fixed-point scaling, gain compensation and half-turn folding.
`default_nettype none

module cpc_pre (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire cpc_pkg::t_cpc_in                         i_data,
    output cpc_pkg::t_cpc_ctl                             o_ctl,
    output logic signed [cpc_pkg::CPC_DATA_BITS-1:0]      o_x,
    output logic signed [cpc_pkg::CPC_DATA_BITS-1:0]      o_y,
    output logic        [cpc_pkg::CPC_ANGLE_BITS-1:0]     o_z
);
    import cpc_pkg::*;

    localparam int DW = CPC_DATA_BITS;
    localparam int AW = CPC_ANGLE_BITS;
    localparam int CB = CPC_COORD_BITS;
    localparam int GB = CPC_GUARD_BITS;
    localparam int PB = CB + AW;       // full product width
    localparam int MB = PB - GB;       // scaled magnitude width

    // stage A
    logic signed [DW-1:0] c_x, c_y, n_a_x, n_a_y;
    logic        [AW-1:0] n_a_z;
    logic        [PB-1:0] c_prod;
    t_cpc_ctl             n_a_ctl;

    t_cpc_ctl             r_a_ctl;
    logic signed [DW-1:0] r_a_x, r_a_y;
    logic        [AW-1:0] r_a_z;
    logic        [MB-1:0] r_a_prod;

    // stage B
    logic signed [DW-1:0] c_px, n_b_x, n_b_y;
    logic        [AW-1:0] c_zq, n_b_z;
    t_cpc_ctl             r_b_ctl;
    logic signed [DW-1:0] r_b_x, r_b_y;
    logic        [AW-1:0] r_b_z;

    always_comb begin
        c_x    = DW'(i_data.in_x) <<< GB;
        c_y    = DW'(i_data.in_y) <<< GB;
        c_prod = PB'(i_data.in_magnitude) * PB'(CPC_INV_GAIN);

        n_a_ctl.valid  = i_valid;
        n_a_ctl.func   = i_data.func;
        n_a_ctl.origin = (i_data.in_x == '0) && (i_data.in_y == '0);

        if (i_data.func == CPC_TO_CART) begin
            n_a_x = '0;
            n_a_y = '0;
            n_a_z = AW'(i_data.in_angle) << (AW - CB);
        end else if (i_data.in_x[CB-1]) begin
            // left half plane: turn by pi first
            n_a_x = -c_x;
            n_a_y = -c_y;
            n_a_z = CPC_HALF_TURN;
        end else begin
            n_a_x = c_x;
            n_a_y = c_y;
            n_a_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (i_en) begin
            r_a_ctl <= n_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= n_a_x;
            r_a_y    <= n_a_y;
            r_a_z    <= n_a_z;
            r_a_prod <= c_prod[PB-1:GB];
        end
    end

    always_comb begin
        c_px = DW'(r_a_prod);
        c_zq = r_a_z + CPC_QUARTER_TURN;
        if (r_a_ctl.func == CPC_TO_CART) begin
            n_b_y = '0;
            // angle outside [-pi/2, pi/2): start from the opposite vector
            if (c_zq[AW-1]) begin
                n_b_x = -c_px;
                n_b_z = r_a_z - CPC_HALF_TURN;
            end else begin
                n_b_x = c_px;
                n_b_z = r_a_z;
            end
        end else begin
            n_b_x = r_a_x;
            n_b_y = r_a_y;
            n_b_z = r_a_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (i_en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x <= n_b_x;
            r_b_y <= n_b_y;
            r_b_z <= n_b_z;
        end
    end

    assign o_ctl = r_b_ctl;
    assign o_x   = r_b_x;
    assign o_y   = r_b_y;
    assign o_z   = r_b_z;

endmodule

`default_nettype wire

>>> hdl/cpc_rot.sv
// One CORDIC micro-rotation stage, registered.
`default_nettype none

module cpc_rot #(
    parameter int STAGE = 0
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire cpc_pkg::t_cpc_ctl                        i_ctl,
    input  wire logic signed [cpc_pkg::CPC_DATA_BITS-1:0] i_x,
    input  wire logic signed [cpc_pkg::CPC_DATA_BITS-1:0] i_y,
    input  wire logic        [cpc_pkg::CPC_ANGLE_BITS-1:0] i_z,
    output cpc_pkg::t_cpc_ctl                             o_ctl,
    output logic signed [cpc_pkg::CPC_DATA_BITS-1:0]      o_x,
    output logic signed [cpc_pkg::CPC_DATA_BITS-1:0]      o_y,
    output logic        [cpc_pkg::CPC_ANGLE_BITS-1:0]     o_z
);
    import cpc_pkg::*;

    localparam int DW = CPC_DATA_BITS;
    localparam int AW = CPC_ANGLE_BITS;
    localparam logic [AW-1:0] ATAN = cpc_atan(5'(STAGE));

    logic                 c_cw;
    logic signed [DW-1:0] c_dx, c_dy, n_x, n_y;
    logic        [AW-1:0] n_z;

    t_cpc_ctl             r_ctl;
    logic signed [DW-1:0] r_x, r_y;
    logic        [AW-1:0] r_z;

    always_comb begin
        c_dx = i_y >>> STAGE;
        c_dy = i_x >>> STAGE;
        // vectoring drives y to zero, rotation drives the residual angle to zero
        if (i_ctl.func == CPC_TO_CART) begin
            c_cw = i_z[AW-1];
        end else begin
            c_cw = !i_y[DW-1];
        end
        if (c_cw) begin
            n_x = i_x + c_dx;
            n_y = i_y - c_dy;
            n_z = i_z + ATAN;
        end else begin
            n_x = i_x - c_dx;
            n_y = i_y + c_dy;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

>>> hdl/cpc_post.sv
// Output stages: gain compensation, angle rounding, truncation and saturation.
`default_nettype none

module cpc_post (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire cpc_pkg::t_cpc_ctl                        i_ctl,
    input  wire logic signed [cpc_pkg::CPC_DATA_BITS-1:0] i_x,
    input  wire logic signed [cpc_pkg::CPC_DATA_BITS-1:0] i_y,
    input  wire logic        [cpc_pkg::CPC_ANGLE_BITS-1:0] i_z,
    output logic                                          o_valid,
    output cpc_pkg::t_cpc_out                             o_data
);
    import cpc_pkg::*;

    localparam int DW = CPC_DATA_BITS;
    localparam int AW = CPC_ANGLE_BITS;
    localparam int CB = CPC_COORD_BITS;
    localparam int GB = CPC_GUARD_BITS;
    localparam int XL = (DW - 1) / 2;          // low slice of the magnitude
    localparam int XH = DW - 1 - XL;           // high slice
    localparam int PW = DW - 1 + AW;           // combined product width
    localparam int MW = PW - AW - GB;          // integer magnitude width
    localparam int TW = DW - GB;               // truncated coordinate width
    localparam int ANG_SHIFT = AW - CB;
    localparam logic [AW:0] ANG_HALF = ((AW+1)'(1) << ANG_SHIFT) >> 1;
    localparam logic signed [DW-1:0] FRAC_MASK = DW'({GB{1'b1}});
    localparam logic signed [TW-1:0] SAT_HI = {{(TW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

    // stage 1
    logic        [XH+AW-1:0] c_ph;
    logic        [XL+AW-1:0] c_pl;
    logic signed [DW-1:0]    c_bx, c_by, c_sx, c_sy;
    logic        [AW-1:0]    c_zr;
    t_cpc_ctl                r1_ctl;
    logic        [XH+AW-1:0] r1_ph;
    logic        [XL+AW-1:0] r1_pl;
    logic signed [TW-1:0]    r1_tx, r1_ty;
    logic        [CB-1:0]    r1_ang;

    // stage 2
    logic signed [CB-1:0]    n2_x, n2_y;
    t_cpc_ctl                r2_ctl;
    logic        [PW-1:0]    r2_sum;
    logic signed [CB-1:0]    r2_x, r2_y;
    logic        [CB-1:0]    r2_ang;

    // stage 3
    logic        [MW-1:0]    c_mag;
    t_cpc_out                n3_out;
    logic                    r3_valid;
    t_cpc_out                r3_out;

    always_comb begin
        // x is never negative after vectoring; split it for two narrow multipliers
        c_ph = (XH+AW)'(i_x[DW-2:XL]) * (XH+AW)'(CPC_INV_GAIN);
        c_pl = (XL+AW)'(i_x[XL-1:0]) * (XL+AW)'(CPC_INV_GAIN);
        // truncate toward zero: bias negatives before the floor shift
        c_bx = i_x[DW-1] ? FRAC_MASK : '0;
        c_by = i_y[DW-1] ? FRAC_MASK : '0;
        c_sx = (i_x + c_bx) >>> GB;
        c_sy = (i_y + c_by) >>> GB;
        c_zr = i_z + ANG_HALF[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl   <= i_ctl;
            r2_ctl   <= r1_ctl;
            r3_valid <= r2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ph  <= c_ph;
            r1_pl  <= c_pl;
            r1_tx  <= c_sx[TW-1:0];
            r1_ty  <= c_sy[TW-1:0];
            r1_ang <= c_zr[AW-1:ANG_SHIFT];
        end
    end

    always_comb begin
        if (r1_tx > SAT_HI) begin
            n2_x = SAT_HI[CB-1:0];
        end else if (r1_tx < SAT_LO) begin
            n2_x = SAT_LO[CB-1:0];
        end else begin
            n2_x = r1_tx[CB-1:0];
        end
        if (r1_ty > SAT_HI) begin
            n2_y = SAT_HI[CB-1:0];
        end else if (r1_ty < SAT_LO) begin
            n2_y = SAT_LO[CB-1:0];
        end else begin
            n2_y = r1_ty[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sum <= (PW'(r1_ph) << XL) + PW'(r1_pl);
            r2_x   <= n2_x;
            r2_y   <= n2_y;
            r2_ang <= r1_ang;
        end
    end

    always_comb begin
        c_mag  = r2_sum[PW-1:AW+GB];
        n3_out = '0;
        if (r2_ctl.func == CPC_TO_CART) begin
            n3_out.out_x = r2_x;
            n3_out.out_y = r2_y;
        end else if (!r2_ctl.origin) begin
            if (c_mag[MW-1:CB] != '0) begin
                n3_out.out_magnitude = '1;
            end else begin
                n3_out.out_magnitude = c_mag[CB-1:0];
            end
            n3_out.out_angle = r2_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_out <= n3_out;
        end
    end

    assign o_valid = r3_valid;
    assign o_data  = r3_out;

endmodule

`default_nettype wire

>>> hdl/cpc_obuf.sv
// Output register with a one-entry skid stage; holds the pipeline while the skid is full.
`default_nettype none

module cpc_obuf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cpc_pkg::t_cpc_out  i_data,
    output logic                    o_en,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cpc_pkg::t_cpc_out       o_data
);
    import cpc_pkg::*;

    logic     r_out_valid, r_skid_valid;
    t_cpc_out r_out, r_skid;
    logic     c_take;

    assign c_take = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // pipeline is held; drain the skid entry first
            if (c_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || c_take) begin
            r_out_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (c_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || c_take) begin
            r_out <= i_data;
        end else begin
            r_skid <= i_data;
        end
    end

    assign o_en    = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

>>> hdl/cartesian_polar_converter.sv
// Top level: pipelined CORDIC cartesian/polar converter.
// Input channel i_valid / o_ready / i_data carries one conversion request; i_data.func
// selects cartesian to polar (x, y in; magnitude, angle out) or polar to cartesian
// (magnitude, angle in; x, y out). Output channel o_valid / i_ready / o_data carries
// exactly one result per request, in request order; fields of the other mode read 0.
// Each rotation stage is one register stage, so one item is taken every cycle
// while o_ready is high. An item passes from the input transfer to o_valid through
// 2 input stages, ROTATION_STAGES rotations, 3 output stages and the output register.
// Throughput is one item per cycle while the receiver keeps i_ready high.
// When the receiver stalls, one more result is caught in a skid register, then
// o_ready drops and the whole pipeline holds; nothing is dropped or repeated.
// o_ready is a register output, so no combinational path runs from i_ready to o_ready.
// Synchronous active-low reset empties the pipeline; o_ready is high after reset.
`default_nettype none

module cartesian_polar_converter #(
    parameter int ROTATION_STAGES = cpc_pkg::CPC_ROTATION_STAGES
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cpc_pkg::t_cpc_in   i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cpc_pkg::t_cpc_out       o_data
);
    import cpc_pkg::*;

    localparam int DW = CPC_DATA_BITS;
    localparam int AW = CPC_ANGLE_BITS;

    logic                 w_en;
    t_cpc_ctl             w_ctl [ROTATION_STAGES+1];
    logic signed [DW-1:0] w_x   [ROTATION_STAGES+1];
    logic signed [DW-1:0] w_y   [ROTATION_STAGES+1];
    logic        [AW-1:0] w_z   [ROTATION_STAGES+1];
    logic                 w_post_valid;
    t_cpc_out             w_post_data;

    cpc_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_ctl   (w_ctl[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0])
    );

    for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_rot
        cpc_rot #(
            .STAGE (g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1])
        );
    end

    cpc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl[ROTATION_STAGES]),
        .i_x     (w_x[ROTATION_STAGES]),
        .i_y     (w_y[ROTATION_STAGES]),
        .i_z     (w_z[ROTATION_STAGES]),
        .o_valid (w_post_valid),
        .o_data  (w_post_data)
    );

    cpc_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_post_valid),
        .i_data  (w_post_data),
        .o_en    (w_en),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    assign o_ready = w_en;

endmodule

`default_nettype wire
